// ===== src/necir_pkg.sv =====
// necir_pkg: shared types and constants for the nec ir frame decoder
// no dependencies; imported by every module of the block

package necir_pkg;

  localparam int unsigned CfgW     = 14;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned NumTimings = 33;

  localparam logic [CfgW-1:0] TimeoutReset = 14'd10000;
  localparam logic [CfgW-1:0] MinZeroReset = 14'd600;
  localparam logic [CfgW-1:0] MinOneReset  = 14'd1000;
  localparam logic [CfgW-1:0] MaxOneReset  = 14'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT_LIMIT = 4'd0,
    CFG_ZERO_LO       = 4'd1,
    CFG_MIN_ONE       = 4'd2,
    CFG_MAX_ONE       = 4'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_BAD_BIT   = 3'd2,
    ST_ADDR_FAIL = 3'd3,
    ST_CMD_FAIL  = 3'd4
  } status_e;

  typedef struct packed {
    logic [CfgW-1:0] timeout_limit;
    logic [CfgW-1:0] zero_lo;
    logic [CfgW-1:0] min_one;
    logic [CfgW-1:0] max_one;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [7:0] address;
    logic [7:0] command;
  } result_t;

endpackage

// ===== src/necir_cfg_regs.sv =====
// necir_cfg_regs: configuration register file of the decoder
// depends on necir_pkg for register indexes, reset values and cfg_t

module necir_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [necir_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [necir_pkg::CfgW-1:0]   wr_data_i,
  output necir_pkg::cfg_t              cfg_o
);
  import necir_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_TIMEOUT_LIMIT: cfg_d.timeout_limit = wr_data_i;
        CFG_ZERO_LO:       cfg_d.zero_lo       = wr_data_i;
        CFG_MIN_ONE:       cfg_d.min_one       = wr_data_i;
        CFG_MAX_ONE:       cfg_d.max_one       = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_limit <= TimeoutReset;
      cfg_q.zero_lo       <= MinZeroReset;
      cfg_q.min_one       <= MinOneReset;
      cfg_q.max_one       <= MaxOneReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/necir_decode.sv =====
// necir_decode: per-sample timing counter, bit classifier and frame checker
// depends on necir_pkg for cfg_t, result_t and status codes

module necir_decode #(
  parameter int unsigned COUNT_WIDTH = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              pin_i,
  input  necir_pkg::cfg_t   cfg_i,
  output necir_pkg::result_t res_o
);
  import necir_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;

  logic                   high_q, high_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [31:0]            shift_q, shift_d;
  logic                   err_q, err_d;

  logic                   fall;
  logic [CmpW-1:0]        len_x;
  logic [CmpW-1:0]        cnt_x;
  logic                   bit_one, bit_bad;
  logic [31:0]            shift_n;
  logic                   err_n;
  logic                   done;
  logic [COUNT_WIDTH-1:0] tick_n;
  logic [7:0]             a, ai, c, ci;

  assign fall  = high_q && !pin_i;
  assign len_x = CmpW'(tick_q);

  always_comb begin
    bit_one = 1'b0;
    bit_bad = 1'b0;
    if (len_x < CmpW'(cfg_i.zero_lo)) begin
      bit_bad = 1'b1;
    end else if (len_x < CmpW'(cfg_i.min_one)) begin
      bit_one = 1'b0;
    end else if (len_x > CmpW'(cfg_i.max_one)) begin
      bit_bad = 1'b1;
    end else begin
      bit_one = 1'b1;
    end
  end

  assign shift_n = (idx_q != '0) ? {shift_q[30:0], bit_one} : shift_q;
  assign err_n   = (idx_q != '0) ? (err_q | bit_bad) : err_q;
  assign done    = (idx_q == IdxW'(NumTimings - 1));

  assign a  = shift_n[31:24];
  assign ai = shift_n[23:16];
  assign c  = shift_n[15:8];
  assign ci = shift_n[7:0];

  always_comb begin
    high_d  = high_q;
    tick_d  = tick_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    err_d   = err_q;
    res_o   = '0;
    if (fall) begin
      high_d  = 1'b0;
      tick_n  = COUNT_WIDTH'(1);
      idx_d   = idx_q + IdxW'(1);
      shift_d = shift_n;
      err_d   = err_n;
    end else begin
      high_d = high_q | pin_i;
      tick_n = (tick_q == {COUNT_WIDTH{1'b1}}) ? tick_q : tick_q + COUNT_WIDTH'(1);
    end
    tick_d = tick_n;
    cnt_x  = CmpW'(tick_n);
    if (fall && done) begin
      idx_d     = '0;
      shift_d   = '0;
      err_d     = 1'b0;
      res_o.valid = 1'b1;
      if (err_n) begin
        res_o.status = ST_BAD_BIT;
      end else if (a != ~ai) begin
        res_o.status = ST_ADDR_FAIL;
      end else if (c != ~ci) begin
        res_o.status = ST_CMD_FAIL;
      end else begin
        res_o.status  = ST_OK;
        res_o.address = a;
        res_o.command = c;
      end
    end else if (cnt_x >= CmpW'(cfg_i.timeout_limit)) begin
      high_d       = 1'b0;
      tick_d       = '0;
      idx_d        = '0;
      shift_d      = '0;
      err_d        = 1'b0;
      res_o.valid  = 1'b1;
      res_o.status = ST_TIMEOUT;
    end
    if (!step_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q  <= 1'b0;
      tick_q  <= '0;
      idx_q   <= '0;
      shift_q <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      high_q  <= high_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== src/nec_ir_frame_decoder_core.sv =====
// nec_ir_frame_decoder_core: nec ir frame decoder, one pin sample per word
// result path: input register, decode, then the result register
// throughput: one sample per cycle, set by the single-pass decode between
// the input register and the result register; stalls only on a held result
// reset: decoder state cleared, config registers back to their defaults

module nec_ir_frame_decoder_core #(
  parameter int unsigned COUNT_WIDTH = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [0] pin_level
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // tdata: [2:0] frame_status, [10:3] ir_address, [18:11] ir_command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [necir_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [necir_pkg::CfgW-1:0]    cfg_data_i
);
  import necir_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic       in_valid_q, in_valid_d;
  logic       pin_q;
  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q;
  logic [7:0] addr_q;
  logic [7:0] cmd_q;
  logic       adv;

  assign cfg_ready_o = 1'b1;

  necir_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  necir_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .pin_i  (pin_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pin_q <= s_axis_tdata[0];
    end
    if (res.valid) begin
      status_q <= res.status;
      addr_q   <= res.address;
      cmd_q    <= res.command;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, cmd_q, addr_q, status_q};

endmodule

// ===== sim/tb_nec_ir_frame_decoder_core.sv =====
// tb_nec_ir_frame_decoder_core: self-checking testbench for the nec ir frame decoder core
// streams pin samples in, predicts every result word and checks it field by field
// depends on necir_pkg and nec_ir_frame_decoder_core
`timescale 1ns / 100ps

module tb_nec_ir_frame_decoder_core;
  import necir_pkg::*;

  localparam int unsigned CountW = 14;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned ItemGoal = 700;

  typedef enum int {
    FK_OK, FK_BAD_BIT, FK_ADDR, FK_CMD, FK_TIMEOUT, FK_NOISE
  } frame_kind_e;

  typedef struct {
    status_e    status;
    logic [7:0] address;
    logic [7:0] command;
  } ir_expect_t;

  class ir_decode_scoreboard;
    logic [CfgW-1:0]   limit_q, zero_min_q, one_min_q, one_max_q;
    bit                high_q;
    logic [CountW-1:0] ticks_q;
    int unsigned       timing_q;
    logic [31:0]       shift_q;
    bit                bad_q;
    ir_expect_t        expected_q[$];
    int unsigned       mismatches, checked, frames;
    int unsigned       by_status[8];

    function new();
      limit_q    = TimeoutReset;
      zero_min_q = MinZeroReset;
      one_min_q  = MinOneReset;
      one_max_q  = MaxOneReset;
      clear_frame();
    endfunction

    function void clear_frame();
      high_q   = 1'b0;
      ticks_q  = '0;
      timing_q = 0;
      shift_q  = '0;
      bad_q    = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_TIMEOUT_LIMIT: limit_q = val;
        CFG_ZERO_LO:       zero_min_q = val;
        CFG_MIN_ONE:       one_min_q = val;
        CFG_MAX_ONE:       one_max_q = val;
        default: ;
      endcase
    endfunction

    function void push(status_e st, logic [7:0] addr, logic [7:0] cmd);
      ir_expect_t r;
      r.status  = st;
      r.address = addr;
      r.command = cmd;
      expected_q.push_back(r);
      if (st != ST_TIMEOUT) frames++;
    endfunction

    function void note_sample(bit pin);
      logic [CountW-1:0] len;
      logic [7:0]        a, ai, c, ci;
      bit                b;
      if (high_q && !pin) begin
        // falling edge closes a timing and opens the next one
        len = ticks_q;
        if (timing_q != 0) begin
          b = 1'b0;
          if (len < zero_min_q) bad_q = 1'b1;
          else if (len < one_min_q) b = 1'b0;
          else if (len > one_max_q) bad_q = 1'b1;
          else b = 1'b1;
          shift_q = {shift_q[30:0], b};
        end
        timing_q++;
        high_q  = 1'b0;
        ticks_q = CountW'(1);
        if (timing_q >= NumTimings) begin
          {a, ai, c, ci} = shift_q;
          if (bad_q) push(ST_BAD_BIT, 8'd0, 8'd0);
          else if (a != ~ai) push(ST_ADDR_FAIL, 8'd0, 8'd0);
          else if (c != ~ci) push(ST_CMD_FAIL, 8'd0, 8'd0);
          else push(ST_OK, a, c);
          timing_q = 0;
          shift_q  = '0;
          bad_q    = 1'b0;
          return;
        end
      end else begin
        if (pin) high_q = 1'b1;
        if (ticks_q != '1) ticks_q++;
      end
      if (ticks_q >= limit_q) begin
        clear_frame();
        push(ST_TIMEOUT, 8'd0, 8'd0);
      end
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_word(logic [23:0] w);
      ir_expect_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result word %h with nothing expected", w));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      by_status[e.status]++;
      if (w[2:0] !== e.status)
        report($sformatf("word %0d status %0d, expected %0d", checked, w[2:0], e.status));
      if (w[10:3] !== e.address)
        report($sformatf("word %0d address %h, expected %h", checked, w[10:3], e.address));
      if (w[18:11] !== e.command)
        report($sformatf("word %0d command %h, expected %h", checked, w[18:11], e.command));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;

  ir_decode_scoreboard sb;
  int unsigned burst_left[2];
  int unsigned hold_cycles;
  int unsigned n_sent;
  int unsigned n_settings;
  int unsigned idle_cycles;

  nec_ir_frame_decoder_core #(
    .COUNT_WIDTH(CountW)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("no word moved for %0d cycles", StallLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly random gaps, now and then a run of back-to-back words
  function automatic int unsigned pick_gap(int side);
    if (burst_left[side] != 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left[side] = $urandom_range(3, 20);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // all driving tasks start and end on a falling edge
  task automatic send_sample(bit pin);
    int unsigned gap;
    gap = pick_gap(0);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, pin};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(pin);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(int unsigned tl, int unsigned z0, int unsigned o1, int unsigned om);
    s_axis_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    write_reg(CFG_TIMEOUT_LIMIT, CfgW'(tl));
    write_reg(CFG_ZERO_LO, CfgW'(z0));
    write_reg(CFG_MIN_ONE, CfgW'(o1));
    write_reg(CFG_MAX_ONE, CfgW'(om));
    n_settings++;
  endtask

  // one timing: some low samples then some high samples, len in total
  task automatic send_timing(int unsigned len);
    int unsigned lows;
    lows = $urandom_range(1, len - 1);
    repeat (lows) send_sample(1'b0);
    repeat (len - lows) send_sample(1'b1);
  endtask

  function automatic int unsigned pick_len(bit one, bit broken);
    int unsigned lo, hi, len;
    if (broken && sb.zero_min_q > 2 && $urandom_range(0, 1) == 1) begin
      len = $urandom_range(2, sb.zero_min_q - 1);
    end else if (broken) begin
      len = sb.one_max_q + 1 + $urandom_range(0, 2);
    end else begin
      lo  = one ? sb.one_min_q : sb.zero_min_q;
      hi  = one ? sb.one_max_q : sb.one_min_q - 1;
      len = $urandom_range(lo, hi);
    end
    if (len < 2) len = 2;
    if (len > sb.limit_q - 2) len = sb.limit_q - 2;
    return len;
  endfunction

  task automatic flush_line();
    repeat (sb.limit_q + 1) send_sample(1'b0);
  endtask

  task automatic send_frame(frame_kind_e kind);
    logic [7:0]  a, c;
    logic [31:0] word;
    int unsigned flip, stop_at;
    int          i;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(5, 40)) send_sample(1'($urandom_range(0, 1)));
      flush_line();
      return;
    end
    a    = 8'($urandom);
    c    = 8'($urandom);
    word = {a, ~a, c, ~c};
    if (kind == FK_ADDR) word[16 + $urandom_range(0, 7)] ^= 1'b1;
    if (kind == FK_CMD) word[$urandom_range(0, 7)] ^= 1'b1;
    flip    = $urandom_range(0, 31);
    stop_at = $urandom_range(0, 31);
    send_timing($urandom_range(2, sb.limit_q - 2));
    for (i = 31; i >= 0; i--) begin
      if (kind == FK_TIMEOUT && i == stop_at) begin
        flush_line();
        return;
      end
      send_timing(pick_len(word[i], kind == FK_BAD_BIT && i == flip));
    end
    send_sample(1'b0);
  endtask

  task automatic send_plain_frame(int unsigned len);
    repeat (NumTimings) send_timing(len);
    send_sample(1'b0);
  endtask

  // result side, with an optional long hold-off requested by the stimulus
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = pick_gap(1);
      end
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_word(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned phase, k, r, guard;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values: a short invalid timing, nothing reported yet
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);

    // smallest limit: every sample times out, and the result side holds off
    configure(1, MinZeroReset, MinOneReset, MaxOneReset);
    hold_cycles = LongHold;
    repeat (60) send_sample(1'($urandom_range(0, 1)));

    // widest limits: all timings read as zeros
    configure(16383, 0, 16383, 16383);
    send_plain_frame(2);

    // thresholds out of order: every timing invalid, then every timing a one
    configure(40, 16383, 0, 0);
    send_plain_frame(2);
    configure(40, 0, 0, 16383);
    send_plain_frame(2);

    phase = 0;
    while (n_sent < ItemGoal) begin
      if (phase % 4 == 3) begin
        // thresholds in no particular order
        configure(8, $urandom_range(2, 4), $urandom_range(2, 4), $urandom_range(2, 4));
      end else begin
        k = $urandom_range(0, 2);
        r = (k < 2 ? 2 : k) + 1;
        guard = r + $urandom_range(0, 1);
        configure(guard + $urandom_range(3, 6), k, r, guard);
      end
      flush_line();
      if (phase == 0) begin
        for (k = 0; k < 6; k++) send_frame(frame_kind_e'(k));
      end else begin
        r = $urandom_range(0, 19);
        if (r < 8) send_frame(FK_OK);
        else if (r < 11) send_frame(FK_BAD_BIT);
        else if (r < 13) send_frame(FK_ADDR);
        else if (r < 15) send_frame(FK_CMD);
        else if (r < 17) send_frame(FK_TIMEOUT);
        else send_frame(FK_NOISE);
      end
      phase++;
    end

    s_axis_tvalid = 1'b0;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (16) @(negedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected result words never arrived", sb.expected_q.size()));

    $display("sent %0d pin samples under %0d register settings, checked %0d result words",
             n_sent, n_settings, sb.checked);
    $display("by status: ok %0d, timeout %0d, bad bit %0d, address %0d, command %0d",
             sb.by_status[ST_OK], sb.by_status[ST_TIMEOUT], sb.by_status[ST_BAD_BIT],
             sb.by_status[ST_ADDR_FAIL], sb.by_status[ST_CMD_FAIL]);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
